>>> hdl/row_zscore_normalizer_defines.svh
// assertion macros for the row z-score normaliser
`ifndef ROW_ZSCORE_NORMALIZER_DEFINES_SVH
`define ROW_ZSCORE_NORMALIZER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RZN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define RZN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rzn_pkg.sv
// shared constants for the row z-score normaliser
package rzn_pkg;

    localparam int RowLen    = 80;
    localparam int Pairs     = (RowLen + 1) / 2;
    localparam int AddrW     = $clog2(RowLen);
    localparam int PairW     = $clog2(Pairs + 1);
    localparam int ValW      = 20;
    localparam int SumW      = 27;
    localparam int SqW       = 47;
    localparam int LenW      = $clog2(RowLen + 1);
    // num < 2^(SqW+LenW); radicand is num << 10, kept even so the root takes whole bit pairs
    localparam int RadW      = ((SqW + LenW + 10 + 1) / 2) * 2;
    localparam int RootW     = (RadW + 1) / 2;
    localparam int DW        = SumW + LenW + 2;
    localparam int DivNumW   = DW + 17;
    localparam int QW        = 21;
    localparam logic [LenW-1:0] RowLenC = LenW'(RowLen);
    localparam bit   OddRow  = (RowLen % 2) == 1;

    localparam logic signed [ValW-1:0] OutMax = 20'sd524287;
    localparam logic signed [ValW-1:0] OutMin = -20'sd524288;

endpackage

>>> hdl/rzn_divider.sv
// iterative restoring divider with rounding and saturation for one normalised value
module rzn_divider
    import rzn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [DW-1:0]   d,
    input  logic [RootW-1:0]       sd,
    output logic                   done,
    output logic signed [ValW-1:0] norm
);

    localparam int CntW = $clog2(DivNumW + 1);

    logic [DivNumW-1:0] quo_reg,  quo_next;
    logic [RootW:0]     rem_reg,  rem_next;
    logic [RootW-1:0]   sd_reg,   sd_next;
    logic               neg_reg,  neg_next;
    logic [CntW-1:0]    cnt_reg,  cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [ValW-1:0] norm_reg, norm_next;

    logic [DW-1:0]      mag;
    logic [RootW+1:0]   trial;
    logic [RootW+1:0]   remsh;
    logic [DivNumW:0]   qround;
    logic [QW-1:0]      qsat;

    always_comb
    begin
        mag   = d[DW-1] ? DW'(-d) : DW'(d);
        remsh = {rem_reg, quo_reg[DivNumW-1]};
        trial = remsh - {2'b00, sd_reg};
        // remainder doubled against divisor decides the round-up
        qround = {1'b0, quo_reg} + ((({rem_reg, 1'b0}) >= {1'b0, sd_reg}) ?
                 (DivNumW+1)'(1) : (DivNumW+1)'(0));
        qsat  = (qround > (DivNumW+1)'(1 << 20)) ? QW'(1 << 20) : qround[QW-1:0];

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        sd_next   = sd_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        norm_next = norm_reg;
        if (start)
        begin
            quo_next  = {mag, 17'd0};
            rem_next  = '0;
            sd_next   = sd;
            neg_next  = d[DW-1];
            cnt_next  = CntW'(DivNumW);
            busy_next = (sd != '0);
            if (sd == '0)
            begin
                done_next = 1'b1;
                norm_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (!trial[RootW+1])
            begin
                rem_next = trial[RootW:0];
                quo_next = {quo_reg[DivNumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = remsh[RootW:0];
                quo_next = {quo_reg[DivNumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(0))
            begin
                quo_next  = quo_reg;
                rem_next  = rem_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                    norm_next = (qsat >= QW'(1 << 19)) ? OutMin : ValW'(-$signed({1'b0, qsat}));
                else
                    norm_next = (qsat > QW'(OutMax)) ? OutMax : ValW'(qsat);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        sd_reg   <= sd_next;
        neg_reg  <= neg_next;
        norm_reg <= norm_next;
    end

    assign done = done_reg;
    assign norm = norm_reg;

endmodule

>>> hdl/row_zscore_normalizer.sv
// Row z-score normaliser. Takes pairs of signed Q7.12 features, stores a row of
// RowLen values in a one-port-write, one-port-read synchronous memory and keeps
// the exact sum and sum of squares. Each accepted pair is followed by a square
// multiply state in which no input is taken. The pair that completes the row
// starts the readout: a multiply state for N*Q and S*S, a bit-per-cycle square
// root, then each stored value is read from memory and put through a bit-serial
// divider. No input is taken during readout. The output register holds one
// result while the readout waits for tready.
`include "row_zscore_normalizer_defines.svh"
module row_zscore_normalizer
    import rzn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value_a [19:0], value_b [39:20]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // norm_a [19:0], norm_b [39:20]
    output logic        m_axis_tlast
);

    typedef enum logic [7:0] {
        ST_IN    = 8'b00000001,
        ST_SQ    = 8'b00000010,
        ST_VAR   = 8'b00000100,
        ST_ROOT  = 8'b00001000,
        ST_RD    = 8'b00010000,
        ST_DIV   = 8'b00100000,
        ST_OUT   = 8'b01000000,
        ST_WAIT  = 8'b10000000
    } state_t;

    localparam int RootCntW = $clog2(RootW + 1);

    state_t state_reg, state_next;

    logic signed [ValW-1:0] row_mem [RowLen];
    logic signed [ValW-1:0] rd_data_reg;

    logic signed [SumW-1:0] sum_reg, sum_next;
    logic [SqW-1:0]         sq_reg,  sq_next;
    logic [PairW-1:0]       pair_reg, pair_next;
    logic signed [ValW-1:0] va_reg, vb_reg;
    logic                   vb_ok_reg;

    logic [RadW-1:0]        nq_reg, ss_reg;
    logic [RadW-1:0]        rad_reg, rad_next;
    logic [RootW-1:0]       root_reg, root_next;
    logic [RootW+1:0]       rrem_reg, rrem_next;
    logic [RootCntW-1:0]    rcnt_reg, rcnt_next;

    logic [AddrW:0]         idx_reg, idx_next;
    logic                   half_reg, half_next;
    logic signed [ValW-1:0] na_reg, na_next;

    logic                   out_valid_reg, out_valid_next;
    logic [39:0]            out_data_reg,  out_data_next;
    logic                   out_last_reg,  out_last_next;

    logic                   in_fire;
    logic [AddrW-1:0]       wr_addr;
    logic                   wr_en;
    logic signed [ValW-1:0] wr_data;
    logic                   div_start;
    logic signed [DW-1:0]   div_d;
    logic                   div_done;
    logic signed [ValW-1:0] div_norm;
    logic [RootW+1:0]       rtrial;
    logic signed [2*ValW-1:0] sqa, sqb;
    logic signed [2*SumW-1:0] sum_sq;
    logic [RadW-1:0]        numv;
    logic                   rd_b_valid;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IN);

    assign sqa = va_reg * va_reg;
    assign sqb = vb_reg * vb_reg;
    assign sum_sq = sum_reg * sum_reg;
    assign numv = (nq_reg > ss_reg) ? (nq_reg - ss_reg) : '0;
    assign rtrial = {rrem_reg[RootW-1:0], rad_reg[RadW-1 -: 2]} - {root_reg, 2'b01};
    assign rd_b_valid = (idx_reg < (AddrW+1)'(RowLen));
    assign div_d = $signed({{(DW-LenW){1'b0}}, RowLenC}) * DW'(rd_data_reg) - DW'(sum_reg);

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        pair_next      = pair_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        rrem_next      = rrem_reg;
        rcnt_next      = rcnt_reg;
        idx_next       = idx_reg;
        half_next      = half_reg;
        na_next        = na_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        div_start      = 1'b0;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IN:
            begin
                if (in_fire)
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                sum_next = sum_reg + SumW'(va_reg) + (vb_ok_reg ? SumW'(vb_reg) : '0);
                sq_next  = sq_reg + SqW'(unsigned'(sqa))
                           + (vb_ok_reg ? SqW'(unsigned'(sqb)) : '0);
                pair_next = pair_reg + PairW'(1);
                state_next = (pair_reg == PairW'(Pairs - 1)) ? ST_VAR : ST_IN;
            end
            ST_VAR:
            begin
                // nq and ss registered here; radicand built next
                state_next = ST_ROOT;
                rad_next   = '0;
                root_next  = '0;
                rrem_next  = '0;
                rcnt_next  = RootCntW'(RootW + 1);
            end
            ST_ROOT:
            begin
                if (rcnt_reg == RootCntW'(RootW + 1))
                begin
                    rad_next  = RadW'({numv, 10'd0});
                    rcnt_next = RootCntW'(RootW);
                end
                else if (rcnt_reg != '0)
                begin
                    rad_next = {rad_reg[RadW-3:0], 2'b00};
                    if (!rtrial[RootW+1])
                    begin
                        rrem_next = rtrial;
                        root_next = {root_reg[RootW-2:0], 1'b1};
                    end
                    else
                    begin
                        rrem_next = {rrem_reg[RootW-1:0], rad_reg[RadW-1 -: 2]};
                        root_next = {root_reg[RootW-2:0], 1'b0};
                    end
                    rcnt_next = rcnt_reg - RootCntW'(1);
                end
                else
                begin
                    idx_next   = '0;
                    half_next  = 1'b0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    if (!half_reg)
                    begin
                        na_next   = div_norm;
                        half_next = 1'b1;
                        idx_next  = idx_reg + (AddrW+1)'(1);
                        state_next = ST_RD;
                        if (OddRow && idx_reg == (AddrW+1)'(RowLen - 1))
                            state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {(half_reg && rd_b_valid) ? div_norm : 20'sd0,
                                      half_reg ? na_reg : div_norm};
                    if (OddRow && !rd_b_valid)
                        out_data_next = {20'sd0, na_reg};
                    out_last_next  = (idx_reg >= (AddrW+1)'(RowLen - 1));
                    half_next      = 1'b0;
                    if (idx_reg >= (AddrW+1)'(RowLen - 1))
                    begin
                        sum_next   = '0;
                        sq_next    = '0;
                        pair_next  = '0;
                        state_next = ST_IN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + (AddrW+1)'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IN;
            end
        endcase

        if (state_reg == ST_SQ)
        begin
            wr_en   = 1'b1;
            wr_addr = AddrW'({pair_reg, 1'b0});
            wr_data = va_reg;
        end
        else if (in_fire && ({pair_reg, 1'b1} < (PairW+1)'(RowLen)))
        begin
            wr_en   = 1'b1;
            wr_addr = AddrW'({pair_reg, 1'b1});
            wr_data = $signed(s_axis_tdata[39:20]);
        end
    end

    // row memory: value a written in the square cycle, value b in the accept cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            row_mem[wr_addr] <= wr_data;
        rd_data_reg <= row_mem[idx_reg[AddrW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            va_reg    <= $signed(s_axis_tdata[19:0]);
            vb_reg    <= $signed(s_axis_tdata[39:20]);
            vb_ok_reg <= ({pair_reg, 1'b1} < (PairW+1)'(RowLen));
        end
        nq_reg   <= RadW'(sq_reg) * RadW'(RowLen);
        ss_reg   <= RadW'(unsigned'(sum_sq));
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rrem_reg <= rrem_next;
        na_reg   <= na_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IN;
            sum_reg       <= '0;
            sq_reg        <= '0;
            pair_reg      <= '0;
            rcnt_reg      <= '0;
            idx_reg       <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            pair_reg      <= pair_next;
            rcnt_reg      <= rcnt_next;
            idx_reg       <= idx_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    rzn_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .d     (div_d),
        .sd    (root_reg),
        .done  (div_done),
        .norm  (div_norm)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    `RZN_ASSERT_IMPL(a_no_input_in_readout, s_axis_tready, state_reg == ST_IN,
        "input taken outside the accept state")
    `RZN_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata),
        "stalled result changed")
    `RZN_ASSERT_IMPL(a_pair_bound, 1'b1, pair_reg <= PairW'(Pairs),
        "pair count ran past the row")
    `RZN_ASSERT_NEXT(a_last_clears,
        state_reg == ST_OUT && (!out_valid_reg || m_axis_tready) && out_last_next,
        pair_reg == '0, "row totals not cleared after last transaction")

endmodule

>>> tb/tb_top.sv
// testbench for the row z-score normaliser: random and directed rows checked against a row predictor
module tb_top;
    import rzn_pkg::*;

    typedef struct packed {
        logic signed [ValW-1:0] norm_a;
        logic signed [ValW-1:0] norm_b;
        logic                   last;
    } norm_pair_t;

    class zscore_board;
        logic signed [ValW-1:0] row_vals[RowLen];
        longint                 row_sum;
        longint unsigned        row_sq;
        int                     pairs_seen;
        norm_pair_t             pending[$];
        int                     errors;

        function new();
            row_sum = 0;
            row_sq = 0;
            pairs_seen = 0;
            errors = 0;
        endfunction

        task report(input string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        function longint unsigned int_sqrt(input longint unsigned n);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= root + bitv)
                begin
                    n -= root + bitv;
                    root = (root >> 1) + bitv;
                end
                else
                    root >>= 1;
                bitv >>= 2;
            end
            return root;
        endfunction

        function logic signed [ValW-1:0] scale(input longint x, input longint unsigned sd);
            longint          d;
            longint unsigned mag;
            longint unsigned q;
            if (sd == 0)
                return '0;
            d = longint'(RowLen) * x - row_sum;
            mag = (d < 0) ? longint'(-d) : d;
            q = ((mag << 17) + sd / 2) / sd;
            if (d >= 0 && q > 524287)
                return OutMax;
            if (d < 0 && q > 524288)
                return OutMin;
            return (d < 0) ? -ValW'(q) : ValW'(q);
        endfunction

        function void add_value(input int idx, input logic signed [ValW-1:0] x);
            longint v;
            if (idx >= RowLen)
                return;
            v = x;
            row_vals[idx] = x;
            row_sum += v;
            row_sq += v * v;
        endfunction

        // a pair went in; the pair that closes the row queues the whole row
        function void note_pair(input logic signed [ValW-1:0] a, input logic signed [ValW-1:0] b);
            longint          num;
            longint unsigned sd;
            norm_pair_t      r;
            add_value(pairs_seen * 2, a);
            add_value(pairs_seen * 2 + 1, b);
            pairs_seen++;
            if (pairs_seen < Pairs)
                return;
            num = longint'(RowLen) * longint'(row_sq) - row_sum * row_sum;
            if (num < 0)
                num = 0;
            sd = int_sqrt(longint'(num) << 10);
            for (int p = 0; p < Pairs; p++)
            begin
                r.norm_a = scale(row_vals[2 * p], sd);
                r.norm_b = (2 * p + 1 < RowLen) ? scale(row_vals[2 * p + 1], sd) : '0;
                r.last = (p == Pairs - 1);
                pending.push_back(r);
            end
            row_sum = 0;
            row_sq = 0;
            pairs_seen = 0;
        endfunction

        task check(input logic [39:0] data, input logic last);
            norm_pair_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected transaction %h", data));
                return;
            end
            e = pending.pop_front();
            if (data[19:0] !== e.norm_a)
                report($sformatf("norm_a %h, want %h", data[19:0], e.norm_a));
            if (data[39:20] !== e.norm_b)
                report($sformatf("norm_b %h, want %h", data[39:20], e.norm_b));
            if (last !== e.last)
                report($sformatf("last %b, want %b", last, e.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // value_a [19:0], value_b [39:20]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // norm_a [19:0], norm_b [39:20]
    logic        m_axis_tlast;

    zscore_board board;
    int          send_idle_pct;
    int          recv_stall_pct;

    row_zscore_normalizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // receiver side: random stalls and result checking
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task send_pair(input logic [19:0] a, input logic [19:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_pair(a, b);
    endtask

    function logic [19:0] pick(input int kind, input logic [19:0] centre);
        case (kind)
            0: return 20'($urandom);
            1: return $urandom_range(1) ? 20'h7ffff : 20'h80000;
            2: return centre + 20'($urandom_range(6)) - 20'd3;
            default: return ($urandom_range(39) == 0) ? 20'($urandom) : centre;
        endcase
    endfunction

    task send_row(input int kind);
        logic [19:0] centre;
        centre = 20'($urandom);
        for (int p = 0; p < Pairs; p++)
            send_pair(pick(kind, centre), pick(kind, centre));
    endtask

    initial
    begin
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // zero variance row at the most negative value, then full-scale extremes
        for (int p = 0; p < Pairs; p++)
            send_pair(20'h80000, 20'h80000);
        send_row(1);
        for (int r = 0; r < 4; r++)
        begin
            case (r % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            send_row(r < 2 ? 0 : $urandom_range(3));
        end
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("tb: failure");
        $finish;
    end
endmodule

>>> files.f
+incdir+hdl
hdl/rzn_pkg.sv
hdl/rzn_divider.sv
hdl/row_zscore_normalizer.sv
tb/tb_top.sv
